// File: hdl/tvrs_pkg.sv
package tvrs_pkg;

  localparam int TAG_BYTES = 7;
  localparam int TAG_W     = 56;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CNT_W     = 16;

  // only the low TAG_BYTES bytes of a tag read take part in compares
  localparam int TAG_KEEP_BITS = (TAG_BYTES >= 7) ? TAG_W : 8 * TAG_BYTES;
  localparam logic [TAG_W-1:0] TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - TAG_KEEP_BITS);

  typedef enum logic [1:0] {
    CFG_REWARD_MS    = 2'd0,
    CFG_PAUSE_MS     = 2'd1,
    CFG_MAX_REWARDS  = 2'd2,
    CFG_MAX_PAUSE_MS = 2'd3
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] REWARD_MS_RST    = 16'd500;
  localparam logic [CFG_W-1:0] PAUSE_MS_RST     = 16'd1000;
  localparam logic [CFG_W-1:0] MAX_REWARDS_RST  = 16'd10;
  localparam logic [CFG_W-1:0] MAX_PAUSE_MS_RST = 16'd5000;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              tag_valid;
    logic [TAG_W-1:0]  tag_id;
    logic              reader_busy;
    logic              poke_in;
  } in_item_t;

  typedef struct packed {
    logic              reward_drive;
    logic              visit_active;
    logic              reward_started;
    logic [CNT_W-1:0]  reward_number;
    logic [TAG_W-1:0]  visit_tag;
  } out_item_t;

  // wrapped difference read as signed; a negative gap never satisfies the limit
  function automatic logic elapsed_at_least(input logic [TIME_W-1:0] now_ms,
                                            input logic [TIME_W-1:0] stamp,
                                            input logic [CFG_W-1:0]  limit);
    logic [TIME_W-1:0] diff;
    diff = now_ms - stamp;
    return !diff[TIME_W-1] && (diff >= {{(TIME_W-CFG_W){1'b0}}, limit});
  endfunction

endpackage

// File: hdl/tag_visit_reward_sequencer_core.sv
// tag visit reward sequencer
// input channel: one poll per transfer (in_valid_i / in_stall_o, payload in_item_i)
//   carrying the millisecond time, an optional tag read, reader busy and poke level
// output channel: one result per poll (out_valid_o / out_stall_i, payload out_item_o)
//   with the actuator level, visit status, reward start flag, count and visit tag
// config: cfg_we_i writes cfg_data_i into the register picked by cfg_idx_i; the user
//   must write only while no poll is in flight, as the block itself does not enforce it
// path: a poll is held in the input register, then its result is written to the
//   result register and offered from there
// throughput: one poll per cycle while the result register is not stalled; the whole visit update is a few 32-bit
//   subtract/compare paths between the input register and the result register
// reset: visit state clears, held tag reads zero, config takes its defaults
//   (reward 500, pause 1000, max rewards 10, max pause 5000), both channels empty
// stall: while the result register is stalled the input register keeps its poll
//   and in_stall_o rises only once that register is occupied, so one more poll
//   is absorbed before the sender sees stall
module tag_visit_reward_sequencer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tvrs_pkg::in_item_t        in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tvrs_pkg::out_item_t       out_item_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [tvrs_pkg::CFG_W-1:0] cfg_data_i
);
  import tvrs_pkg::*;

  // config registers
  logic [CFG_W-1:0] reward_ms_q, pause_ms_q, max_rewards_q, max_pause_ms_q;

  // input register
  logic     in_valid_q;
  in_item_t in_q;

  // result register
  logic      out_valid_q;
  out_item_t out_q;

  // visit state
  logic              tag_held_q, poke_active_q, pulse_active_q;
  logic [TAG_W-1:0]  held_tag_q;
  logic [TIME_W-1:0] last_poke_time_q, pulse_time_q, tag_time_q;
  logic [CNT_W-1:0]  reward_count_q;

  logic              tag_held_d, poke_active_d, pulse_active_d;
  logic [TAG_W-1:0]  held_tag_d;
  logic [TIME_W-1:0] last_poke_time_d, pulse_time_d, tag_time_d;
  logic [CNT_W-1:0]  reward_count_d;
  logic              started_d, active_d;
  logic [TAG_W-1:0]  tag_m;

  logic fire;

  // process the held poll when the result register is free or draining
  assign fire        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reward_ms_q    <= REWARD_MS_RST;
      pause_ms_q     <= PAUSE_MS_RST;
      max_rewards_q  <= MAX_REWARDS_RST;
      max_pause_ms_q <= MAX_PAUSE_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REWARD_MS:    reward_ms_q    <= cfg_data_i;
        CFG_PAUSE_MS:     pause_ms_q     <= cfg_data_i;
        CFG_MAX_REWARDS:  max_rewards_q  <= cfg_data_i;
        CFG_MAX_PAUSE_MS: max_pause_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register: refills on every transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // visit update for the poll in the input register
  always_comb begin
    tag_held_d       = tag_held_q;
    held_tag_d       = held_tag_q;
    poke_active_d    = poke_active_q;
    pulse_active_d   = pulse_active_q;
    last_poke_time_d = last_poke_time_q;
    pulse_time_d     = pulse_time_q;
    tag_time_d       = tag_time_q;
    reward_count_d   = reward_count_q;
    started_d        = 1'b0;
    active_d         = 1'b1;
    tag_m            = in_q.tag_id & TAG_MASK;

    if (in_q.tag_valid) begin
      // different tag: drop the old visit before taking the new one
      if (tag_held_q && (tag_m != held_tag_q)) begin
        poke_active_d    = 1'b0;
        pulse_active_d   = 1'b0;
        last_poke_time_d = '0;
        pulse_time_d     = '0;
        reward_count_d   = '0;
      end
      tag_held_d = 1'b1;
      tag_time_d = in_q.now_ms;
      held_tag_d = tag_m;
    end

    if (tag_held_d) begin
      poke_active_d = in_q.poke_in;
      if (in_q.poke_in) begin
        last_poke_time_d = in_q.now_ms;
      end
      if (pulse_active_d) begin
        // pulse ends after reward time
        if (elapsed_at_least(in_q.now_ms, pulse_time_d, reward_ms_q)) begin
          pulse_active_d = 1'b0;
          pulse_time_d   = in_q.now_ms;
        end
      end else if (in_q.poke_in) begin
        if (elapsed_at_least(in_q.now_ms, pulse_time_d, pause_ms_q) &&
            (reward_count_d < max_rewards_q)) begin
          pulse_active_d = 1'b1;
          pulse_time_d   = in_q.now_ms;
          reward_count_d = reward_count_d + 1'b1;
          started_d      = 1'b1;
        end
      end
    end

    // idle test: end the visit once everything has been quiet for max pause
    if (!(poke_active_d || pulse_active_d || in_q.reader_busy) &&
        elapsed_at_least(in_q.now_ms, last_poke_time_d, max_pause_ms_q) &&
        elapsed_at_least(in_q.now_ms, tag_time_d, max_pause_ms_q)) begin
      active_d         = 1'b0;
      tag_held_d       = 1'b0;
      poke_active_d    = 1'b0;
      pulse_active_d   = 1'b0;
      last_poke_time_d = '0;
      pulse_time_d     = '0;
      tag_time_d       = '0;
      reward_count_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_held_q       <= 1'b0;
      held_tag_q       <= '0;
      poke_active_q    <= 1'b0;
      pulse_active_q   <= 1'b0;
      last_poke_time_q <= '0;
      pulse_time_q     <= '0;
      tag_time_q       <= '0;
      reward_count_q   <= '0;
    end else if (fire) begin
      tag_held_q       <= tag_held_d;
      held_tag_q       <= held_tag_d;
      poke_active_q    <= poke_active_d;
      pulse_active_q   <= pulse_active_d;
      last_poke_time_q <= last_poke_time_d;
      pulse_time_q     <= pulse_time_d;
      tag_time_q       <= tag_time_d;
      reward_count_q   <= reward_count_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.reward_drive   <= pulse_active_d;
      out_q.visit_active   <= active_d;
      out_q.reward_started <= started_d;
      out_q.reward_number  <= reward_count_d;
      out_q.visit_tag      <= held_tag_d;
    end
  end

`ifndef SYNTH
  a_start_drives : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.reward_started |-> out_q.reward_drive && (out_q.reward_number != '0))
    else $error("reward start without drive or count");

  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !active_d |=> !tag_held_q && !pulse_active_q && (reward_count_q == '0))
    else $error("visit end left state behind");

  a_poll_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_q))
    else $error("waiting poll lost");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && started_d |=> reward_count_q == $past(reward_count_q) + 1'b1 ||
                          reward_count_q == 16'd1)
    else $error("reward count did not advance");
`endif

endmodule
